/* hdl/u2wa_pkg.sv */
// ----------------------------------------------------------------------------
// u2wa_pkg
// Shared types, character constants and lookup functions for the UTF-8 to
// WinAnsi literal-string unit.
// ----------------------------------------------------------------------------
package u2wa_pkg;

   // number of output bytes one input byte can produce at most
   localparam int unsigned RunMax = 5;

   // continuation bytes still expected
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // characters used by the escaping rules
   localparam logic [6:0] CH_QMARK  = 7'h3F;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_LPAREN = 7'h28;
   localparam logic [6:0] CH_RPAREN = 7'h29;
   localparam logic [3:0] CH_DIGIT_HI = 4'b0110;
   localparam logic [4:0] CH_DIGIT_HI2 = 5'b01100;

   // code points that map into the 0x80..0x9f range
   localparam logic [15:0] CP_EURO   = 16'h20AC;
   localparam logic [15:0] CP_BULLET = 16'h2022;
   localparam logic [15:0] CP_ENDASH = 16'h2013;
   localparam logic [15:0] CP_EMDASH = 16'h2014;
   localparam logic [15:0] CP_LSQUO  = 16'h2018;
   localparam logic [15:0] CP_RSQUO  = 16'h2019;
   localparam logic [15:0] CP_LDQUO  = 16'h201C;
   localparam logic [15:0] CP_RDQUO  = 16'h201D;

   localparam logic [9:0] FALLBACK_WIDTH = 10'd556;

   // advance widths of the printable characters 32..126
   localparam logic [9:0] ADVANCE [0:94] = '{
      10'd278, 10'd278, 10'd355, 10'd556, 10'd556, 10'd889, 10'd667, 10'd191,
      10'd333, 10'd333, 10'd389, 10'd584, 10'd278, 10'd333, 10'd278, 10'd278,
      10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556,
      10'd556, 10'd556, 10'd278, 10'd278, 10'd584, 10'd584, 10'd584, 10'd556,
      10'd1015, 10'd667, 10'd667, 10'd722, 10'd722, 10'd667, 10'd611, 10'd778,
      10'd722, 10'd278, 10'd500, 10'd667, 10'd556, 10'd833, 10'd722, 10'd778,
      10'd667, 10'd778, 10'd722, 10'd667, 10'd611, 10'd722, 10'd667, 10'd944,
      10'd667, 10'd667, 10'd611, 10'd278, 10'd278, 10'd278, 10'd469, 10'd556,
      10'd333, 10'd556, 10'd556, 10'd500, 10'd556, 10'd556, 10'd278, 10'd556,
      10'd556, 10'd222, 10'd222, 10'd500, 10'd222, 10'd833, 10'd556, 10'd556,
      10'd556, 10'd556, 10'd333, 10'd500, 10'd278, 10'd556, 10'd500, 10'd722,
      10'd500, 10'd500, 10'd500, 10'd334, 10'd260, 10'd334, 10'd584
   };

   // open multi-byte sequence
   typedef struct packed {
      logic [1:0] pending;
      logic [9:0] partial;
   } seq_type;

   // escaped form of one winansi byte
   typedef struct packed {
      logic [3:0][6:0] ch;
      logic [2:0]      len;
   } esc_type;

   // all output bytes caused by one input byte
   typedef struct packed {
      logic [RunMax-1:0][6:0] ch;
      logic [RunMax-1:0][9:0] width;
      logic [2:0]             count;
   } run_type;

   // code point to winansi byte
   function automatic logic [7:0] winansi_of(input logic [15:0] code);
      logic [7:0] w;
      w = {1'b0, CH_QMARK};
      if (code < 16'h0080 || (code >= 16'h00A0 && code <= 16'h00FF)) begin
         w = code[7:0];
      end else begin
         unique case (code)
            CP_EURO:   w = 8'h80;
            CP_BULLET: w = 8'h95;
            CP_ENDASH: w = 8'h96;
            CP_EMDASH: w = 8'h97;
            CP_LSQUO:  w = 8'h91;
            CP_RSQUO:  w = 8'h92;
            CP_LDQUO:  w = 8'h93;
            CP_RDQUO:  w = 8'h94;
            default:   w = {1'b0, CH_QMARK};
         endcase
      end
      return w;
   endfunction

   // literal-string escaping of one byte
   function automatic esc_type escape_byte(input logic [7:0] w);
      esc_type e;
      e = '0;
      if (w == {1'b0, CH_LPAREN} || w == {1'b0, CH_RPAREN} || w == {1'b0, CH_BSLASH}) begin
         e.len   = 3'd2;
         e.ch[0] = CH_BSLASH;
         e.ch[1] = w[6:0];
      end else if (w < 8'd32 || w > 8'd126) begin
         e.len   = 3'd4;
         e.ch[0] = CH_BSLASH;
         e.ch[1] = {CH_DIGIT_HI2, w[7:6]};
         e.ch[2] = {CH_DIGIT_HI, w[5:3]};
         e.ch[3] = {CH_DIGIT_HI, w[2:0]};
      end else begin
         e.len   = 3'd1;
         e.ch[0] = w[6:0];
      end
      return e;
   endfunction

   // advance width of an output character
   function automatic logic [9:0] advance_of(input logic [6:0] ch);
      logic [6:0] idx;
      logic [9:0] adv;
      idx = ch - 7'd32;
      adv = FALLBACK_WIDTH;
      if (ch >= 7'd32 && ch != 7'd127) begin
         adv = ADVANCE[idx];
      end
      return adv;
   endfunction

endpackage

/* hdl/u2wa_encoder.sv */
// ----------------------------------------------------------------------------
// u2wa_encoder
// Combinational decode of one UTF-8 byte against the open sequence: next
// sequence state and the escaped output bytes with their widths.
// ----------------------------------------------------------------------------
module u2wa_encoder (
   input  logic [7:0]        in_byte,
   input  logic              last_byte,
   input  u2wa_pkg::seq_type seq_cur,
   output u2wa_pkg::seq_type seq_next,
   output u2wa_pkg::run_type run
);

   logic             emit_one;
   logic             emit_trunc;
   logic [7:0]       wa_byte;
   u2wa_pkg::esc_type esc;

   // sequence tracking and choice of the winansi byte
   always_comb begin
      seq_next   = seq_cur;
      emit_one   = 1'b0;
      emit_trunc = 1'b0;
      wa_byte    = {1'b0, u2wa_pkg::CH_QMARK};
      unique case (seq_cur.pending)
         u2wa_pkg::PEND_ONE: begin
            seq_next = '0;
            emit_one = 1'b1;
            wa_byte  = u2wa_pkg::winansi_of({seq_cur.partial, in_byte[5:0]});
         end
         u2wa_pkg::PEND_TWO: begin
            if (last_byte) begin
               // truncated three-byte sequence: '?' then the final byte alone
               seq_next   = '0;
               emit_trunc = 1'b1;
               wa_byte    = in_byte[7] ? {1'b0, u2wa_pkg::CH_QMARK} : in_byte;
            end else begin
               seq_next.pending = u2wa_pkg::PEND_ONE;
               seq_next.partial = {seq_cur.partial[3:0], in_byte[5:0]};
            end
         end
         default: begin
            seq_next = '0;
            if (!in_byte[7]) begin
               emit_one = 1'b1;
               wa_byte  = in_byte;
            end else if (in_byte[7:5] == 3'b110 && !last_byte) begin
               seq_next.pending = u2wa_pkg::PEND_ONE;
               seq_next.partial = {5'd0, in_byte[4:0]};
            end else if (in_byte[7:4] == 4'b1110 && !last_byte) begin
               seq_next.pending = u2wa_pkg::PEND_TWO;
               seq_next.partial = {6'd0, in_byte[3:0]};
            end else begin
               emit_one = 1'b1;
            end
         end
      endcase
      // end of string closes any open sequence
      if (last_byte) begin
         seq_next = '0;
      end
   end

   assign esc = u2wa_pkg::escape_byte(wa_byte);

   // lay out the output run and attach widths
   always_comb begin
      run = '0;
      if (emit_trunc) begin
         run.ch[0]   = u2wa_pkg::CH_QMARK;
         run.ch[4:1] = esc.ch;
         run.count   = 3'd1 + esc.len;
      end else if (emit_one) begin
         run.ch[3:0] = esc.ch;
         run.count   = esc.len;
      end
      for (int i = 0; i < u2wa_pkg::RunMax; i++) begin
         run.width[i] = u2wa_pkg::advance_of(run.ch[i]);
      end
   end

endmodule

/* hdl/utf8_to_pdf_winansi_literal_unit.sv */
// ----------------------------------------------------------------------------
// utf8_to_pdf_winansi_literal_unit
// UTF-8 byte stream in, escaped WinAnsi literal-string bytes out.
// ----------------------------------------------------------------------------
// A request is one UTF-8 byte; it is decoded in the cycle it is accepted and
// its output bytes (zero to five) are loaded into a run register that drains
// one byte per cycle while results are taken. After a byte producing one
// output byte a new request is accepted every cycle as long as results are
// taken; a byte producing more output bytes holds off the next request until
// its last byte leaves the single-byte-per-cycle result port. Bytes that only
// open or extend a multi-byte sequence produce no result and leave the unit
// ready for the next request. run_end marks the last output of a request,
// string_end the last output of a request with last_byte set.
module utf8_to_pdf_winansi_literal_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_byte,
   output logic [9:0] rsp_glyph_width,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);

   u2wa_pkg::seq_type seq_ff, seq_in, seq_dec;
   u2wa_pkg::run_type run_dec;
   logic [u2wa_pkg::RunMax-1:0][6:0] ch_ff, ch_in;
   logic [u2wa_pkg::RunMax-1:0][9:0] width_ff, width_in;
   logic [2:0] count_ff, count_in;
   logic       str_end_ff, str_end_in;
   logic       req_take;
   logic       rsp_take;

   u2wa_encoder u_encoder (
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .seq_cur   (seq_ff),
      .seq_next  (seq_dec),
      .run       (run_dec)
   );

   // handshake: accept when the run register is empty or its last byte leaves
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);
   assign req_take  = req_valid && req_ready;

   // result port
   assign rsp_out_byte    = ch_ff[0];
   assign rsp_glyph_width = width_ff[0];
   assign rsp_run_end     = (count_ff == 3'd1);
   assign rsp_string_end  = (count_ff == 3'd1) && str_end_ff;

   // next values: load on a request, shift on a taken result
   always_comb begin
      seq_in     = seq_ff;
      ch_in      = ch_ff;
      width_in   = width_ff;
      count_in   = count_ff;
      str_end_in = str_end_ff;
      if (req_take) begin
         seq_in     = seq_dec;
         ch_in      = run_dec.ch;
         width_in   = run_dec.width;
         count_in   = run_dec.count;
         str_end_in = req_last_byte;
      end else if (rsp_take) begin
         for (int i = 0; i < u2wa_pkg::RunMax - 1; i++) begin
            ch_in[i]    = ch_ff[i+1];
            width_in[i] = width_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= '0;
         count_ff   <= 3'd0;
         str_end_ff <= 1'b0;
      end else begin
         seq_ff     <= seq_in;
         count_ff   <= count_in;
         str_end_ff <= str_end_in;
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      width_ff <= width_in;
   end

endmodule

/* hdl/u2wa_checker.sv */
// ----------------------------------------------------------------------------
// u2wa_checker
// Port-level checks of the literal-string unit, bound to the top level.
// ----------------------------------------------------------------------------
module u2wa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_byte,
   input logic [9:0] rsp_glyph_width,
   input logic       rsp_run_end,
   input logic       rsp_string_end
);

   // a stalled result holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // no new request while more bytes of the current one remain
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> !req_ready)
      else $error("request accepted mid-run");

   // string end only on the last byte of a run
   a_str_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

   // only printable bytes leave the unit
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte >= 7'd32 && rsp_out_byte != 7'd127)
      else $error("non-printable output byte");

   // widths stay inside the font's range
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_glyph_width >= 10'd191 && rsp_glyph_width <= 10'd1015)
      else $error("glyph width out of range");

endmodule

bind utf8_to_pdf_winansi_literal_unit u2wa_checker u_checker (.*);

/* tb/utf8_to_pdf_winansi_literal_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_pdf_winansi_literal_unit_tb
// Drives UTF-8 byte strings into the transcoder and checks every escaped
// output byte, its advance width and its end flags against a local model of
// the decoder. A short directed table comes first, then random strings built
// mostly from well-formed characters with some noise and truncated endings.
// ----------------------------------------------------------------------------
module utf8_to_pdf_winansi_literal_unit_tb;

   localparam int unsigned RANDOM_BYTES   = 256;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned CALM_FIRST     = 120;
   localparam int unsigned CALM_LAST      = 200;

   localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
   localparam logic [6:0]  CH_ZERO        = 7'h30;

   // advance of printable characters 32..126, in 1/1000 em
   localparam logic [9:0] GLYPH_ADVANCE [0:94] = '{
      10'd278, 10'd278, 10'd355, 10'd556, 10'd556, 10'd889, 10'd667, 10'd191, 10'd333,
      10'd333, 10'd389, 10'd584, 10'd278, 10'd333, 10'd278, 10'd278, 10'd556, 10'd556,
      10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd556, 10'd278,
      10'd278, 10'd584, 10'd584, 10'd584, 10'd556, 10'd1015, 10'd667, 10'd667, 10'd722,
      10'd722, 10'd667, 10'd611, 10'd778, 10'd722, 10'd278, 10'd500, 10'd667, 10'd556,
      10'd833, 10'd722, 10'd778, 10'd667, 10'd778, 10'd722, 10'd667, 10'd611, 10'd722,
      10'd667, 10'd944, 10'd667, 10'd667, 10'd611, 10'd278, 10'd278, 10'd278, 10'd469,
      10'd556, 10'd333, 10'd556, 10'd556, 10'd500, 10'd556, 10'd556, 10'd278, 10'd556,
      10'd556, 10'd222, 10'd222, 10'd500, 10'd222, 10'd833, 10'd556, 10'd556, 10'd556,
      10'd556, 10'd333, 10'd500, 10'd278, 10'd556, 10'd500, 10'd722, 10'd500, 10'd500,
      10'd500, 10'd334, 10'd260, 10'd334, 10'd584
   };

   localparam logic [15:0] PUNCT_CODES [0:7] = '{
      u2wa_pkg::CP_EURO, u2wa_pkg::CP_BULLET, u2wa_pkg::CP_ENDASH, u2wa_pkg::CP_EMDASH,
      u2wa_pkg::CP_LSQUO, u2wa_pkg::CP_RSQUO, u2wa_pkg::CP_LDQUO, u2wa_pkg::CP_RDQUO
   };

   // one output byte of the literal
   typedef struct packed {
      logic [6:0] out_byte;
      logic [9:0] glyph_width;
      logic       run_end;
      logic       string_end;
   } glyph_type;

   // one input byte; fixed holds the typed-in output text, zero if predicted
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [39:0] fixed;
   } utf8_req_type;

   localparam int unsigned DIRECTED_COUNT = 24;
   localparam utf8_req_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{8'h41, 1'b0, "A"},
      '{8'h20, 1'b0, " "},
      '{8'h7E, 1'b0, "~"},
      '{8'h01, 1'b0, "\\001"},
      '{8'h7F, 1'b0, "\\177"},
      '{8'h28, 1'b0, "\\("},
      '{8'h29, 1'b0, "\\)"},
      '{8'h5C, 1'b0, "\\\\"},
      // latin-1 pair ending the string
      '{8'hC3, 1'b0, ""},
      '{8'hA9, 1'b1, ""},
      // euro sign and em dash
      '{8'hE2, 1'b0, ""},
      '{8'h82, 1'b0, ""},
      '{8'hAC, 1'b0, ""},
      '{8'hE2, 1'b0, ""},
      '{8'h80, 1'b0, ""},
      '{8'h94, 1'b0, ""},
      // stray continuation, 4-byte lead, lead cut off by end of string
      '{8'h80, 1'b0, "?"},
      '{8'hF0, 1'b0, "?"},
      '{8'hC3, 1'b1, "?"},
      // truncated 3-byte sequences: ascii tail, then non-ascii tail
      '{8'hE2, 1'b0, ""},
      '{8'h41, 1'b1, "?A"},
      '{8'hE2, 1'b0, ""},
      '{8'h80, 1'b1, "??"},
      '{8'hFF, 1'b1, "?"}
   };

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h20;
   logic       req_last_byte  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [6:0] rsp_out_byte;
   logic [9:0] rsp_glyph_width;
   logic       rsp_run_end;
   logic       rsp_string_end;

   logic        calm          = 1'b0;
   logic [39:0] active_fixed  = '0;
   int unsigned error_count   = 0;
   int unsigned quiet_cycles  = 0;

   utf8_req_type utf8_stream [$];
   glyph_type    expected_glyphs [$];
   glyph_type    step_glyphs [$];

   // decoder state of the local model
   logic [1:0]  seq_pending   = u2wa_pkg::PEND_NONE;
   logic [9:0]  seq_bits      = '0;

   utf8_to_pdf_winansi_literal_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_glyph_width (rsp_glyph_width),
      .rsp_run_end     (rsp_run_end),
      .rsp_string_end  (rsp_string_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [9:0] char_advance(input logic [6:0] ch);
      if (ch >= 7'd32 && ch <= 7'd126) begin
         return GLYPH_ADVANCE[ch - 7'd32];
      end
      return 10'd556;
   endfunction

   function automatic logic [7:0] winansi_byte(input logic [15:0] cp);
      if (cp < 16'h0080 || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
         return cp[7:0];
      end
      case (cp)
         u2wa_pkg::CP_EURO:   return 8'h80;
         u2wa_pkg::CP_BULLET: return 8'h95;
         u2wa_pkg::CP_ENDASH: return 8'h96;
         u2wa_pkg::CP_EMDASH: return 8'h97;
         u2wa_pkg::CP_LSQUO:  return 8'h91;
         u2wa_pkg::CP_RSQUO:  return 8'h92;
         u2wa_pkg::CP_LDQUO:  return 8'h93;
         u2wa_pkg::CP_RDQUO:  return 8'h94;
         default:             return {1'b0, u2wa_pkg::CH_QMARK};
      endcase
   endfunction

   task automatic add_glyph(input logic [6:0] ch);
      glyph_type g;
      g.out_byte    = ch;
      g.glyph_width = char_advance(ch);
      g.run_end     = 1'b0;
      g.string_end  = 1'b0;
      step_glyphs.insert(step_glyphs.size(), g);
   endtask

   // map a code point and write it in literal-string form
   task automatic add_code_point(input logic [15:0] cp);
      logic [7:0] w;
      w = winansi_byte(cp);
      if (w == {1'b0, u2wa_pkg::CH_LPAREN} || w == {1'b0, u2wa_pkg::CH_RPAREN}
          || w == {1'b0, u2wa_pkg::CH_BSLASH}) begin
         add_glyph(u2wa_pkg::CH_BSLASH);
         add_glyph(w[6:0]);
      end else if (w < 8'd32 || w > 8'd126) begin
         add_glyph(u2wa_pkg::CH_BSLASH);
         add_glyph(CH_ZERO + {5'd0, w[7:6]});
         add_glyph(CH_ZERO + {4'd0, w[5:3]});
         add_glyph(CH_ZERO + {4'd0, w[2:0]});
      end else begin
         add_glyph(w[6:0]);
      end
   endtask

   task automatic clear_sequence();
      seq_pending = u2wa_pkg::PEND_NONE;
      seq_bits    = '0;
   endtask

   // decode one byte into step_glyphs and advance the model state
   task automatic transcode_byte(input logic [7:0] b, input logic last);
      step_glyphs.delete();
      case (seq_pending)
         u2wa_pkg::PEND_ONE: begin
            logic [15:0] cp;
            cp = {seq_bits, b[5:0]};
            clear_sequence();
            add_code_point(cp);
         end
         u2wa_pkg::PEND_TWO: begin
            if (last) begin
               clear_sequence();
               add_code_point(CP_REPLACEMENT);
               add_code_point(b < 8'h80 ? {8'h00, b} : CP_REPLACEMENT);
            end else begin
               seq_bits    = {seq_bits[3:0], b[5:0]};
               seq_pending = u2wa_pkg::PEND_ONE;
            end
         end
         default: begin
            clear_sequence();
            if (b < 8'h80) begin
               add_code_point({8'h00, b});
            end else if (b[7:5] == 3'b110 && !last) begin
               seq_pending = u2wa_pkg::PEND_ONE;
               seq_bits    = {5'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110 && !last) begin
               seq_pending = u2wa_pkg::PEND_TWO;
               seq_bits    = {6'd0, b[3:0]};
            end else begin
               add_code_point(CP_REPLACEMENT);
            end
         end
      endcase
      if (last) begin
         clear_sequence();
      end
   endtask

   // one random string: mostly well-formed characters, sometimes a cut-off tail
   task automatic append_random_string();
      logic [7:0]   text [$];
      logic [15:0]  cp;
      int unsigned  kind;
      int unsigned  nchars;
      utf8_req_type r;
      nchars = $urandom_range(10, 1);
      repeat (nchars) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            text.insert(text.size(), 8'($urandom_range(127, 1)));
         end else if (kind < 55) begin
            if ($urandom_range(1)) begin
               cp = 16'($urandom_range(255, 128));
               text.insert(text.size(), {6'b110000, cp[7:6]});
               text.insert(text.size(), {2'b10, cp[5:0]});
            end else begin
               text.insert(text.size(), 8'($urandom_range(8'hDF, 8'hC0)));
               text.insert(text.size(), 8'($urandom_range(8'hBF, 8'h80)));
            end
         end else if (kind < 75) begin
            if ($urandom_range(1)) begin
               cp = PUNCT_CODES[3'($urandom_range(7))];
               text.insert(text.size(), {4'hE, cp[15:12]});
               text.insert(text.size(), {2'b10, cp[11:6]});
               text.insert(text.size(), {2'b10, cp[5:0]});
            end else begin
               text.insert(text.size(), 8'($urandom_range(8'hEF, 8'hE0)));
               text.insert(text.size(), 8'($urandom_range(8'hBF, 8'h80)));
               text.insert(text.size(), 8'($urandom_range(8'hBF, 8'h80)));
            end
         end else if (kind < 85) begin
            text.insert(text.size(), 8'($urandom_range(255, 1)));
         end else if (kind < 90) begin
            text.insert(text.size(), 8'($urandom_range(8'hF7, 8'hF0)));
            repeat (3) text.insert(text.size(), 8'($urandom_range(8'hBF, 8'h80)));
         end else begin
            case ($urandom_range(2))
               0:       text.insert(text.size(), {1'b0, u2wa_pkg::CH_LPAREN});
               1:       text.insert(text.size(), {1'b0, u2wa_pkg::CH_RPAREN});
               default: text.insert(text.size(), {1'b0, u2wa_pkg::CH_BSLASH});
            endcase
         end
      end
      // cut-off ending: a bare lead, or a 3-byte lead with one more byte
      if ($urandom_range(99) < 20) begin
         if ($urandom_range(1)) begin
            text.insert(text.size(), 8'($urandom_range(8'hEF, 8'hC0)));
         end else begin
            text.insert(text.size(), 8'($urandom_range(8'hEF, 8'hE0)));
            text.insert(text.size(), 8'($urandom_range(255, 1)));
         end
      end
      foreach (text[i]) begin
         r.data  = text[i];
         r.last  = (i == text.size() - 1);
         r.fixed = '0;
         utf8_stream.insert(utf8_stream.size(), r);
      end
   endtask

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin : scoreboard
      glyph_type  want;
      logic [7:0] c;
      if (!reset) begin
         if (req_valid && req_ready) begin
            transcode_byte(req_in_byte, req_last_byte);
            if (active_fixed != '0) begin
               step_glyphs.delete();
               for (int i = 4; i >= 0; i--) begin
                  c = active_fixed[i*8 +: 8];
                  if (c != 8'h00) add_glyph(c[6:0]);
               end
            end
            if (step_glyphs.size() > 0) begin
               step_glyphs[step_glyphs.size()-1].run_end    = 1'b1;
               step_glyphs[step_glyphs.size()-1].string_end = req_last_byte;
            end
            foreach (step_glyphs[i])
               expected_glyphs.insert(expected_glyphs.size(), step_glyphs[i]);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_glyphs.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h", rsp_out_byte));
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_glyph_width !== want.glyph_width)
                  report_mismatch($sformatf("glyph_width %0d, want %0d",
                                            rsp_glyph_width, want.glyph_width));
               if (rsp_run_end !== want.run_end)
                  report_mismatch($sformatf("run_end %b, want %b",
                                            rsp_run_end, want.run_end));
               if (rsp_string_end !== want.string_end)
                  report_mismatch($sformatf("string_end %b, want %b",
                                            rsp_string_end, want.string_end));
            end
         end
      end
   end

   // result-side stalls, none during the calm stretch
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 14);
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // request stream: directed table, then random strings
   initial begin : stimulus
      utf8_req_type r;
      for (int i = 0; i < DIRECTED_COUNT; i++)
         utf8_stream.insert(utf8_stream.size(), DIRECTED_ROWS[i]);
      while (utf8_stream.size() < DIRECTED_COUNT + RANDOM_BYTES) append_random_string();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (utf8_stream[idx]) begin
         r    = utf8_stream[idx];
         calm = (idx >= CALM_FIRST && idx < CALM_LAST);
         while (!calm && $urandom_range(99) < 14) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_in_byte   <= r.data;
         req_last_byte <= r.last;
         active_fixed   = r.fixed;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      calm       = 1'b0;

      wait (expected_glyphs.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_glyphs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_glyphs.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* utf8_to_pdf_winansi_literal_unit.f */
hdl/u2wa_pkg.sv
hdl/u2wa_encoder.sv
hdl/utf8_to_pdf_winansi_literal_unit.sv
hdl/u2wa_checker.sv
tb/utf8_to_pdf_winansi_literal_unit_tb.sv
